// ===== sv/laplace_double_layer_kernel_assert.svh =====
// assertion macros for the laplace double layer kernel block
// used by the port checker; needs clk and rst_n in scope
`ifndef LAPLACE_DOUBLE_LAYER_KERNEL_ASSERT_SVH
`define LAPLACE_DOUBLE_LAYER_KERNEL_ASSERT_SVH

// clocked check, off while reset is low
`define LDLK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define LDLK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ldlk_pkg.sv =====
// shared widths, constants and pipeline payload types for the
// laplace double layer kernel; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ldlk_pkg;

    // field widths
    localparam int COORD_WIDTH_DEF = 32;
    localparam int NORM_W          = 32;
    localparam int OUT_W           = 32;

    // internal datapath widths
    localparam int M_W           = 16;
    localparam int K_W           = 8;
    localparam int MAG_W         = 49;
    localparam int R2_W          = 34;
    localparam int ROOT_W        = 30;
    localparam int SQRT_PRESHIFT = 26;
    localparam int SQ_IN_W       = R2_W + SQRT_PRESHIFT;
    localparam int C_W           = 64;
    localparam int PI_W          = 32;
    localparam int DEN_W         = C_W + PI_W;
    localparam int DEN_SH_MAX    = 7;
    localparam int DN_W          = DEN_W + DEN_SH_MAX;
    localparam int E_BASE        = 59;
    localparam int E_MAX         = 89;
    localparam int Q_W           = 33;
    localparam int NUM_W         = MAG_W + E_MAX;
    localparam int TOP_W         = NUM_W - Q_W;

    // pi in Q2.30
    localparam logic [PI_W-1:0] PI_Q2_30 = 32'd3373259426;

    // result limits
    localparam logic [OUT_W-1:0] KV_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] KV_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // geometry result: numerator magnitude, r2, scale and flags
    typedef struct packed {
        logic [MAG_W-1:0]      mag;
        logic                  neg;
        logic [R2_W-1:0]       r2;
        logic signed [K_W-1:0] k;
        logic                  singular;
        logic                  zero;
    } geo_t;

    // geometry plus square root
    typedef struct packed {
        geo_t              geo;
        logic [ROOT_W-1:0] root;
    } rt_t;

    // divider operands and flags
    typedef struct packed {
        logic [DN_W-1:0] dn;
        logic [DN_W-1:0] rem;
        logic [Q_W-1:0]  nlow;
        logic            sat;
        logic            neg;
        logic            singular;
        logic            zero;
    } quo_t;

endpackage

`default_nettype wire

// ===== sv/ldlk_front.sv =====
// front end: difference vector, normalization, dot product and r2
// depends on ldlk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ldlk_front #(
    parameter int COORD_WIDTH = ldlk_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_WIDTH-1:0]       test_x,
    input  logic signed [COORD_WIDTH-1:0]       test_y,
    input  logic signed [COORD_WIDTH-1:0]       test_z,
    input  logic signed [COORD_WIDTH-1:0]       trial_x,
    input  logic signed [COORD_WIDTH-1:0]       trial_y,
    input  logic signed [COORD_WIDTH-1:0]       trial_z,
    input  logic signed [ldlk_pkg::NORM_W-1:0]  normal_x,
    input  logic signed [ldlk_pkg::NORM_W-1:0]  normal_y,
    input  logic signed [ldlk_pkg::NORM_W-1:0]  normal_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ldlk_pkg::geo_t                      geo
);
    import ldlk_pkg::*;

    localparam int A_W  = COORD_WIDTH + 1;
    localparam int L_W  = $clog2(A_W + 1);
    localparam int NS   = 5;
    localparam int P_W  = M_W + 1 + NORM_W;
    localparam int S_W  = P_W + 2;
    localparam int SQ_W = 2 * M_W;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   stall;

    logic signed [COORD_WIDTH-1:0] tst [3];
    logic signed [COORD_WIDTH-1:0] trl [3];
    logic signed [NORM_W-1:0]      nrm [3];

    // stage 1
    logic signed [A_W-1:0] d [3];
    logic [A_W-1:0]        s1_a_next [3];
    logic [2:0]            s1_negd_next;
    logic [A_W-1:0]        s1_a_reg [3];
    logic [2:0]            s1_negd_reg;
    logic signed [NORM_W-1:0] s1_n_reg [3];

    // stage 2
    logic [A_W-1:0]        or_v;
    logic [L_W-1:0]        blen;
    logic signed [K_W-1:0] s2_k_next;
    logic                  s2_sing_next;
    logic [A_W-1:0]        s2_a_reg [3];
    logic [2:0]            s2_negd_reg;
    logic signed [NORM_W-1:0] s2_n_reg [3];
    logic signed [K_W-1:0] s2_k_reg;
    logic                  s2_sing_reg;

    // stage 3
    logic [K_W-1:0]        amt;
    logic [A_W-1:0]        sh [3];
    logic [M_W-1:0]        s3_m_next [3];
    logic [M_W-1:0]        s3_m_reg [3];
    logic [2:0]            s3_negd_reg;
    logic signed [NORM_W-1:0] s3_n_reg [3];
    logic signed [K_W-1:0] s3_k_reg;
    logic                  s3_sing_reg;

    // stage 4
    logic signed [M_W:0]   sm [3];
    logic signed [P_W-1:0] s4_p_next [3];
    logic [SQ_W-1:0]       s4_sq_next [3];
    logic signed [P_W-1:0] s4_p_reg [3];
    logic [SQ_W-1:0]       s4_sq_reg [3];
    logic signed [K_W-1:0] s4_k_reg;
    logic                  s4_sing_reg;

    // stage 5
    logic signed [S_W-1:0] s;
    logic signed [S_W-1:0] sa;
    geo_t                  geo_next;
    geo_t                  geo_reg;

    assign tst[0] = test_x;
    assign tst[1] = test_y;
    assign tst[2] = test_z;
    assign trl[0] = trial_x;
    assign trl[1] = trial_y;
    assign trl[2] = trial_z;
    assign nrm[0] = normal_x;
    assign nrm[1] = normal_y;
    assign nrm[2] = normal_z;

    // per stage stall chain
    assign stall[NS] = out_stall;
    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_stall
            assign stall[g] = vld_reg[g] & stall[g+1];
        end
    endgenerate
    assign in_stall  = stall[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (!stall[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (!stall[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // difference and absolute value per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i] = {trl[i][COORD_WIDTH-1], trl[i]} - {tst[i][COORD_WIDTH-1], tst[i]};
            s1_negd_next[i] = d[i][A_W-1];
            s1_a_next[i] = d[i][A_W-1] ? (~d[i] + 1'b1) : d[i];
        end
    end

    // bit length of the largest axis sets the scale
    always_comb
    begin
        or_v = s1_a_reg[0] | s1_a_reg[1] | s1_a_reg[2];
        blen = '0;
        for (int i = 0; i < A_W; i++)
        begin
            if (or_v[i])
            begin
                blen = L_W'(i + 1);
            end
        end
        s2_k_next    = $signed(K_W'(M_W)) - $signed(K_W'(blen));
        s2_sing_next = (or_v == '0);
    end

    // normalize to 16 bit magnitudes
    always_comb
    begin
        amt = s2_k_reg[K_W-1] ? K_W'(-s2_k_reg) : K_W'(s2_k_reg);
        for (int i = 0; i < 3; i++)
        begin
            sh[i] = s2_k_reg[K_W-1] ? (s2_a_reg[i] >> amt) : (s2_a_reg[i] << amt);
            s3_m_next[i] = sh[i][M_W-1:0];
        end
    end

    // signed products with the normal, squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sm[i] = s3_negd_reg[i] ? -$signed({1'b0, s3_m_reg[i]})
                                   : $signed({1'b0, s3_m_reg[i]});
            s4_p_next[i]  = sm[i] * s3_n_reg[i];
            s4_sq_next[i] = s3_m_reg[i] * s3_m_reg[i];
        end
    end

    // sums, sign and magnitude of the numerator
    always_comb
    begin
        s  = S_W'(s4_p_reg[0]) + S_W'(s4_p_reg[1]) + S_W'(s4_p_reg[2]);
        sa = s[S_W-1] ? -s : s;
        geo_next.mag      = sa[MAG_W-1:0];
        geo_next.neg      = !s[S_W-1] && (s != '0);
        geo_next.r2       = R2_W'(s4_sq_reg[0]) + R2_W'(s4_sq_reg[1])
                          + R2_W'(s4_sq_reg[2]);
        geo_next.k        = s4_k_reg;
        geo_next.singular = s4_sing_reg;
        geo_next.zero     = (s == '0);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!stall[0])
        begin
            s1_a_reg    <= s1_a_next;
            s1_negd_reg <= s1_negd_next;
            s1_n_reg    <= nrm;
        end
        if (!stall[1])
        begin
            s2_a_reg    <= s1_a_reg;
            s2_negd_reg <= s1_negd_reg;
            s2_n_reg    <= s1_n_reg;
            s2_k_reg    <= s2_k_next;
            s2_sing_reg <= s2_sing_next;
        end
        if (!stall[2])
        begin
            s3_m_reg    <= s3_m_next;
            s3_negd_reg <= s2_negd_reg;
            s3_n_reg    <= s2_n_reg;
            s3_k_reg    <= s2_k_reg;
            s3_sing_reg <= s2_sing_reg;
        end
        if (!stall[3])
        begin
            s4_p_reg    <= s4_p_next;
            s4_sq_reg   <= s4_sq_next;
            s4_k_reg    <= s3_k_reg;
            s4_sing_reg <= s3_sing_reg;
        end
        if (!stall[4])
        begin
            geo_reg <= geo_next;
        end
    end

    assign geo = geo_reg;

endmodule

`default_nettype wire

// ===== sv/ldlk_sqrt.sv =====
// pipelined integer square root of r2 scaled by 2^26, one root bit per stage
// depends on ldlk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ldlk_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ldlk_pkg::geo_t geo_in,
    output logic           out_valid,
    input  logic           out_stall,
    output ldlk_pkg::rt_t  rt
);
    import ldlk_pkg::*;

    localparam int NS  = ROOT_W;
    localparam int SQW = SQ_IN_W + 1;

    logic [NS-1:0]     vld_reg;
    logic [NS:0]       stall;

    logic [SQW-1:0]    rem_src [NS];
    logic [ROOT_W-1:0] root_src [NS];
    geo_t              geo_src [NS];
    logic [SQW-1:0]    trial [NS];
    logic [SQW-1:0]    rem_next [NS];
    logic [ROOT_W-1:0] root_next [NS];
    logic [SQW-1:0]    rem_reg [NS];
    logic [ROOT_W-1:0] root_reg [NS];
    geo_t              geo_reg [NS];

    // per stage stall chain
    assign stall[NS] = out_stall;
    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_stall
            assign stall[g] = vld_reg[g] & stall[g+1];
        end
        for (g = 1; g < NS; g++)
        begin : g_src
            assign rem_src[g]  = rem_reg[g-1];
            assign root_src[g] = root_reg[g-1];
            assign geo_src[g]  = geo_reg[g-1];
        end
    endgenerate
    assign in_stall  = stall[0];
    assign out_valid = vld_reg[NS-1];

    assign rem_src[0]  = SQW'({geo_in.r2, {SQRT_PRESHIFT{1'b0}}});
    assign root_src[0] = '0;
    assign geo_src[0]  = geo_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (!stall[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (!stall[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage j decides root bit ROOT_W-1-j: (r + 2^b)^2 - r^2 against remainder
    always_comb
    begin
        for (int j = 0; j < NS; j++)
        begin
            trial[j] = (SQW'(root_src[j]) << (ROOT_W - j))
                     + (SQW'(1) << (2 * (ROOT_W - 1 - j)));
            if (rem_src[j] >= trial[j])
            begin
                rem_next[j]  = rem_src[j] - trial[j];
                root_next[j] = root_src[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end
            else
            begin
                rem_next[j]  = rem_src[j];
                root_next[j] = root_src[j];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (!stall[i])
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                geo_reg[i]  <= geo_src[i];
            end
        end
    end

    assign rt.geo  = geo_reg[NS-1];
    assign rt.root = root_reg[NS-1];

endmodule

`default_nettype wire

// ===== sv/ldlk_den.sv =====
// denominator r2 * root * pi in split multiplies, numerator alignment
// and the overflow test ahead of the divider; depends on ldlk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ldlk_den (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ldlk_pkg::rt_t  rt,
    output logic           out_valid,
    input  logic           out_stall,
    output ldlk_pkg::quo_t quo
);
    import ldlk_pkg::*;

    localparam int NS     = 6;
    localparam int HALF   = R2_W / 2;
    localparam int PH_W   = HALF + ROOT_W;
    localparam int CH_W   = C_W / 2;
    localparam int DL_W   = CH_W + PI_W;
    localparam int DSH_W  = $clog2(DEN_SH_MAX + 1);

    logic [NS-1:0] vld_reg;
    logic [NS:0]   stall;

    // stage 1
    logic [PH_W-1:0] d1_pa_next, d1_pb_next;
    logic [PH_W-1:0] d1_pa_reg, d1_pb_reg;
    geo_t            d1_geo_reg;
    // stage 2
    logic [C_W-1:0]  d2_c_next;
    logic [C_W-1:0]  d2_c_reg;
    geo_t            d2_geo_reg;
    // stage 3
    logic signed [K_W-1:0] e;
    logic [K_W-2:0]  esh;
    logic [DL_W-1:0] d3_dl_next, d3_dh_next;
    logic [DSH_W-1:0] d3_dsh_next;
    logic [NUM_W-1:0] d3_num_next;
    logic [DL_W-1:0] d3_dl_reg, d3_dh_reg;
    logic [DSH_W-1:0] d3_dsh_reg;
    logic [NUM_W-1:0] d3_num_reg;
    geo_t            d3_geo_reg;
    // stage 4
    logic [DEN_W-1:0] d4_den_next;
    logic [DEN_W-1:0] d4_den_reg;
    logic [DSH_W-1:0] d4_dsh_reg;
    logic [NUM_W-1:0] d4_num_reg;
    geo_t            d4_geo_reg;
    // stage 5
    logic [DN_W-1:0] d5_dn_next;
    logic [DN_W-1:0] d5_dn_reg;
    logic [NUM_W-1:0] d5_num_reg;
    geo_t            d5_geo_reg;
    // stage 6
    logic [TOP_W-1:0] ntop;
    quo_t            quo_next;
    quo_t            quo_reg;

    // per stage stall chain
    assign stall[NS] = out_stall;
    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_stall
            assign stall[g] = vld_reg[g] & stall[g+1];
        end
    endgenerate
    assign in_stall  = stall[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (!stall[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (!stall[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // r2 * root as two partial products
    assign d1_pa_next = rt.geo.r2[HALF-1:0] * rt.root;
    assign d1_pb_next = rt.geo.r2[R2_W-1:HALF] * rt.root;

    assign d2_c_next = C_W'(d1_pa_reg) + (C_W'(d1_pb_reg) << HALF);

    // times pi as two partial products; exponent and numerator shift
    always_comb
    begin
        d3_dl_next  = d2_c_reg[CH_W-1:0] * PI_Q2_30;
        d3_dh_next  = d2_c_reg[C_W-1:CH_W] * PI_Q2_30;
        e           = $signed(K_W'(E_BASE)) + ($signed(d2_geo_reg.k) <<< 1);
        esh         = e[K_W-1] ? '0 : e[K_W-2:0];
        d3_dsh_next = e[K_W-1] ? DSH_W'(-e) : '0;
        d3_num_next = NUM_W'(d2_geo_reg.mag) << esh;
    end

    assign d4_den_next = DEN_W'(d3_dl_reg) + (DEN_W'(d3_dh_reg) << CH_W);

    // a negative exponent moves onto the denominator
    assign d5_dn_next = DN_W'(d4_den_reg) << d4_dsh_reg;

    // quotient of 2^Q_W or more can only saturate
    always_comb
    begin
        ntop              = d5_num_reg[NUM_W-1:Q_W];
        quo_next.dn       = d5_dn_reg;
        quo_next.rem      = ntop[DN_W-1:0];
        quo_next.nlow     = d5_num_reg[Q_W-1:0];
        quo_next.sat      = (ntop >= TOP_W'(d5_dn_reg));
        quo_next.neg      = d5_geo_reg.neg;
        quo_next.singular = d5_geo_reg.singular;
        quo_next.zero     = d5_geo_reg.zero;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!stall[0])
        begin
            d1_pa_reg  <= d1_pa_next;
            d1_pb_reg  <= d1_pb_next;
            d1_geo_reg <= rt.geo;
        end
        if (!stall[1])
        begin
            d2_c_reg   <= d2_c_next;
            d2_geo_reg <= d1_geo_reg;
        end
        if (!stall[2])
        begin
            d3_dl_reg  <= d3_dl_next;
            d3_dh_reg  <= d3_dh_next;
            d3_dsh_reg <= d3_dsh_next;
            d3_num_reg <= d3_num_next;
            d3_geo_reg <= d2_geo_reg;
        end
        if (!stall[3])
        begin
            d4_den_reg <= d4_den_next;
            d4_dsh_reg <= d3_dsh_reg;
            d4_num_reg <= d3_num_reg;
            d4_geo_reg <= d3_geo_reg;
        end
        if (!stall[4])
        begin
            d5_dn_reg  <= d5_dn_next;
            d5_num_reg <= d4_num_reg;
            d5_geo_reg <= d4_geo_reg;
        end
        if (!stall[5])
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ===== sv/ldlk_div.sv =====
// pipelined restoring divider, one quotient bit per stage, then rounding,
// saturation and sign in the output register; depends on ldlk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ldlk_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ldlk_pkg::quo_t                     quo,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ldlk_pkg::OUT_W-1:0]  kernel_value,
    output logic                               singular,
    output logic                               saturated
);
    import ldlk_pkg::*;

    localparam int NS = Q_W + 1;

    logic [NS-1:0]   vld_reg;
    logic [NS:0]     stall;

    quo_t            op_src [Q_W];
    logic [Q_W-1:0]  q_src [Q_W];
    logic [DN_W:0]   t [Q_W];
    logic [DN_W:0]   diff [Q_W];
    logic [Q_W-1:0]  take;
    quo_t            op_next [Q_W];
    logic [Q_W-1:0]  q_next [Q_W];
    quo_t            op_reg [Q_W];
    logic [Q_W-1:0]  q_reg [Q_W];

    // output stage
    quo_t            last;
    logic            rnd;
    logic [Q_W:0]    q1;
    logic [Q_W:0]    lim;
    logic            sat_all;
    logic [OUT_W-1:0] mag;
    logic [OUT_W-1:0] kv_next;
    logic            sing_next;
    logic            sat_next;
    logic [OUT_W-1:0] kv_reg;
    logic            sing_reg;
    logic            sat_reg;

    // per stage stall chain
    assign stall[NS] = out_stall;
    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_stall
            assign stall[g] = vld_reg[g] & stall[g+1];
        end
        for (g = 1; g < Q_W; g++)
        begin : g_src
            assign op_src[g] = op_reg[g-1];
            assign q_src[g]  = q_reg[g-1];
        end
    endgenerate
    assign in_stall  = stall[0];
    assign out_valid = vld_reg[NS-1];

    assign op_src[0] = quo;
    assign q_src[0]  = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (!stall[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (!stall[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        for (int j = 0; j < Q_W; j++)
        begin
            t[j]    = {op_src[j].rem, op_src[j].nlow[Q_W-1]};
            diff[j] = t[j] - {1'b0, op_src[j].dn};
            take[j] = (t[j] >= {1'b0, op_src[j].dn});
            op_next[j]      = op_src[j];
            op_next[j].rem  = take[j] ? diff[j][DN_W-1:0] : t[j][DN_W-1:0];
            op_next[j].nlow = op_src[j].nlow << 1;
            q_next[j]       = {q_src[j][Q_W-2:0], take[j]};
        end
    end

    // round half up, clamp, apply sign, special cases
    always_comb
    begin
        last    = op_reg[Q_W-1];
        rnd     = ({last.rem, 1'b0} >= {1'b0, last.dn});
        q1      = {1'b0, q_reg[Q_W-1]} + (Q_W+1)'(rnd);
        lim     = (Q_W+1)'(KV_MAX) + (Q_W+1)'(last.neg);
        sat_all = last.sat || (q1 > lim);
        mag     = sat_all ? lim[OUT_W-1:0] : q1[OUT_W-1:0];
        if (last.singular)
        begin
            kv_next   = '0;
            sing_next = 1'b1;
            sat_next  = 1'b0;
        end
        else if (last.zero)
        begin
            kv_next   = '0;
            sing_next = 1'b0;
            sat_next  = 1'b0;
        end
        else
        begin
            kv_next   = last.neg ? (~mag + 1'b1) : mag;
            sing_next = 1'b0;
            sat_next  = sat_all;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_W; i++)
        begin
            if (!stall[i])
            begin
                op_reg[i] <= op_next[i];
                q_reg[i]  <= q_next[i];
            end
        end
        if (!stall[NS-1])
        begin
            kv_reg   <= kv_next;
            sing_reg <= sing_next;
            sat_reg  <= sat_next;
        end
    end

    assign kernel_value = $signed(kv_reg);
    assign singular     = sing_reg;
    assign saturated    = sat_reg;

endmodule

`default_nettype wire

// ===== sv/laplace_double_layer_kernel.sv =====
// laplace 3d double layer kernel: front, square root, denominator and divider
// pipelines plus an output register, from accept to result;
// one item per cycle unless stalled; each stage stalls only when it is full and blocked
// reset clears the stage valid bits; the datapath registers are not reset
// top level; depends on ldlk_pkg, ldlk_front, ldlk_sqrt, ldlk_den, ldlk_div
`timescale 1ns / 1ps
`default_nettype none

module laplace_double_layer_kernel #(
    parameter int COORD_WIDTH = ldlk_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_WIDTH-1:0]      test_x,
    input  logic signed [COORD_WIDTH-1:0]      test_y,
    input  logic signed [COORD_WIDTH-1:0]      test_z,
    input  logic signed [COORD_WIDTH-1:0]      trial_x,
    input  logic signed [COORD_WIDTH-1:0]      trial_y,
    input  logic signed [COORD_WIDTH-1:0]      trial_z,
    input  logic signed [ldlk_pkg::NORM_W-1:0] normal_x,
    input  logic signed [ldlk_pkg::NORM_W-1:0] normal_y,
    input  logic signed [ldlk_pkg::NORM_W-1:0] normal_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ldlk_pkg::OUT_W-1:0]  kernel_value,
    output logic                               singular,
    output logic                               saturated
);
    import ldlk_pkg::*;

    logic fr_valid, fr_stall;
    logic sq_valid, sq_stall;
    logic dn_valid, dn_stall;
    geo_t geo;
    rt_t  rt;
    quo_t quo;

    // geometry and dot products
    ldlk_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .test_x    (test_x),
        .test_y    (test_y),
        .test_z    (test_z),
        .trial_x   (trial_x),
        .trial_y   (trial_y),
        .trial_z   (trial_z),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .out_valid (fr_valid),
        .out_stall (fr_stall),
        .geo       (geo)
    );

    // square root
    ldlk_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .geo_in    (geo),
        .out_valid (sq_valid),
        .out_stall (sq_stall),
        .rt        (rt)
    );

    // denominator and alignment
    ldlk_den u_den (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_stall  (sq_stall),
        .rt        (rt),
        .out_valid (dn_valid),
        .out_stall (dn_stall),
        .quo       (quo)
    );

    // divider and output
    ldlk_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dn_valid),
        .in_stall     (dn_stall),
        .quo          (quo),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kernel_value (kernel_value),
        .singular     (singular),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

// ===== sv/ldlk_port_check.sv =====
// port level checks on the result channel of the kernel block, bound
// to the top level; depends on ldlk_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "laplace_double_layer_kernel_assert.svh"

module ldlk_port_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [ldlk_pkg::OUT_W-1:0] kernel_value,
    input  logic                              singular,
    input  logic                              saturated
);
    import ldlk_pkg::*;

    // stalled item stays
    `LDLK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
    `LDLK_ASSERT(a_data_hold, out_valid && out_stall |=> $stable(kernel_value) && $stable(singular) && $stable(saturated), "result changed under stall")

    // coincident points give a clean zero
    `LDLK_ASSERT_ALWAYS(a_sing_zero, out_valid && singular |-> kernel_value == '0 && !saturated, "singular item not zero")

    // saturation only at the range ends
    `LDLK_ASSERT(a_sat_limit, out_valid && saturated |-> kernel_value == $signed(KV_MAX) || kernel_value == $signed(KV_MIN), "saturated value off the limit")

endmodule

bind laplace_double_layer_kernel ldlk_port_check u_check (.*);

`default_nettype wire

// ===== test/laplace_double_layer_kernel_test.sv =====
// testbench for the laplace double layer kernel: directed table, then random point pairs
// checked against an in-bench fixed point predictor; depends on ldlk_pkg and the block
`timescale 1ns / 1ps

module laplace_double_layer_kernel_test;

    import ldlk_pkg::*;

    localparam int CW            = COORD_WIDTH_DEF;
    localparam int N_RANDOM      = 430;
    localparam int QUIET_FROM    = 380;
    localparam int PAUSE_AT      = 200;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int DRAIN_CYCLES  = 120;

    // one point pair
    typedef struct {
        logic signed [CW-1:0]     tst [3];
        logic signed [CW-1:0]     trl [3];
        logic signed [NORM_W-1:0] nrm [3];
    } pair_t;

    // one kernel result
    typedef struct {
        logic [OUT_W-1:0] kv;
        logic             sing;
        logic             sat;
    } kernel_t;

    // directed row: pair plus optional typed-in answer
    typedef struct {
        pair_t   pr;
        bit      typed;
        kernel_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] test_x, test_y, test_z;
    logic signed [CW-1:0] trial_x, trial_y, trial_z;
    logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_W-1:0] kernel_value;
    logic singular;
    logic saturated;

    kernel_t pending_kernels [$];
    int      fails;
    int      idle_cycles;
    bit      quiet;

    laplace_double_layer_kernel DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .test_x(test_x), .test_y(test_y), .test_z(test_z),
        .trial_x(trial_x), .trial_y(trial_y), .trial_z(trial_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .kernel_value(kernel_value), .singular(singular), .saturated(saturated)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // fixed point double layer kernel of one pair
    function automatic kernel_t double_layer_value(input pair_t p);
        kernel_t          r;
        longint           d;
        longint unsigned  a [3];
        longint unsigned  m [3];
        bit               nd [3];
        longint unsigned  mx, r2, root, c, mag, q, lim, t;
        longint           num;
        int               k, e, len, i;
        logic [191:0]     den, numer, quo, rem;
        bit               neg, sat;
        r.kv = '0;
        r.sing = 1'b0;
        r.sat = 1'b0;
        mx = 0;
        for (i = 0; i < 3; i++)
        begin
            d = longint'(p.trl[i]) - longint'(p.tst[i]);
            nd[i] = d < 0;
            a[i] = nd[i] ? longint'(-d) : d;
            if (a[i] > mx)
                mx = a[i];
        end
        if (mx == 0)
        begin
            r.sing = 1'b1;
            return r;
        end
        len = 0;
        t = mx;
        while (t != 0)
        begin
            len++;
            t = t >> 1;
        end
        k = 16 - len;
        r2 = 0;
        num = 0;
        for (i = 0; i < 3; i++)
        begin
            m[i] = (k >= 0) ? (a[i] << k) : (a[i] >> (-k));
            r2 += m[i] * m[i];
            num += (nd[i] ? -longint'(m[i]) : longint'(m[i])) * longint'(p.nrm[i]);
        end
        if (num == 0)
            return r;
        root = floor_sqrt(r2 << SQRT_PRESHIFT);
        c = r2 * root;
        den = 192'(c) * 192'(PI_Q2_30);
        e = E_BASE + 2 * k;
        neg = num > 0;
        mag = (num < 0) ? longint'(-num) : num;
        if (e >= 0)
            numer = 192'(mag) << e;
        else
        begin
            numer = 192'(mag);
            den = den << (-e);
        end
        quo = numer / den;
        rem = numer % den;
        sat = quo > (192'd1 << 32);
        q = quo[63:0];
        if (!sat && ((rem << 1) >= den))
            q++;
        lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        if (sat || q > lim)
        begin
            sat = 1'b1;
            q = lim;
        end
        r.kv = neg ? (32'd0 - q[31:0]) : q[31:0];
        r.sat = sat;
        return r;
    endfunction

    // pack nine coordinates into one pair
    function automatic pair_t build_pair(input longint tx, ty, tz, sx, sy, sz, nx, ny, nz);
        pair_t p;
        p.tst[0] = CW'(tx); p.tst[1] = CW'(ty); p.tst[2] = CW'(tz);
        p.trl[0] = CW'(sx); p.trl[1] = CW'(sy); p.trl[2] = CW'(sz);
        p.nrm[0] = NORM_W'(nx); p.nrm[1] = NORM_W'(ny); p.nrm[2] = NORM_W'(nz);
        return p;
    endfunction

    function automatic logic signed [NORM_W-1:0] rand_normal();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int    i;
        int    mode;
        mode = $urandom_range(0, 19);
        for (i = 0; i < 3; i++)
        begin
            p.tst[i] = $urandom;
            p.nrm[i] = rand_normal();
            if (mode < 12)
                p.trl[i] = p.tst[i] + (int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            else if (mode < 14)
                p.trl[i] = p.tst[i] + (int'($urandom_range(0, 64)) - 32);
            else if (mode == 14)
                p.trl[i] = p.tst[i];
            else
                p.trl[i] = $urandom;
            if (mode == 15)
                p.nrm[i] = '0;
        end
        return p;
    endfunction

    // send one item and record its expectation at acceptance
    task automatic send_pair(input pair_t p, input bit typed, input kernel_t want);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        test_x <= p.tst[0]; test_y <= p.tst[1]; test_z <= p.tst[2];
        trial_x <= p.trl[0]; trial_y <= p.trl[1]; trial_z <= p.trl[2];
        normal_x <= p.nrm[0]; normal_y <= p.nrm[1]; normal_z <= p.nrm[2];
        do
            @(posedge clk);
        while (in_stall);
        pending_kernels.push_back(typed ? want : double_layer_value(p));
    endtask

    // stimulus
    initial
    begin
        row_t    rows [$];
        row_t    rw;
        kernel_t none;
        int      i;
        none = '{kv: '0, sing: 1'b0, sat: 1'b0};
        fails = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        test_x = '0; test_y = '0; test_z = '0;
        trial_x = '0; trial_y = '0; trial_z = '0;
        normal_x = '0; normal_y = '0; normal_z = '0;

        // coincident points at zero and at the extremes
        rows.push_back('{build_pair(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{kv: '0, sing: 1'b1, sat: 1'b0}});
        rows.push_back('{build_pair(-2147483648, 2147483647, -2147483648,
                                    -2147483648, 2147483647, -2147483648,
                                    32'sh4000_0000, 0, 0), 1,
                         '{kv: '0, sing: 1'b1, sat: 1'b0}});
        // zero numerator: zero normal and perpendicular normal
        rows.push_back('{build_pair(0, 0, 0, 65536, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{build_pair(0, 0, 0, 65536, 0, 0, 0, 32'sh4000_0000, 0), 1, none});
        // one lsb apart: far out of range, both signs
        rows.push_back('{build_pair(0, 0, 0, 1, 0, 0, 32'sh4000_0000, 0, 0), 1,
                         '{kv: KV_MIN, sing: 1'b0, sat: 1'b1}});
        rows.push_back('{build_pair(0, 0, 0, 1, 0, 0, -32'sh4000_0000, 0, 0), 1,
                         '{kv: KV_MAX, sing: 1'b0, sat: 1'b1}});
        // extremes and other pairs checked by the predictor
        rows.push_back('{build_pair(-2147483648, -2147483648, -2147483648,
                                    2147483647, 2147483647, 2147483647,
                                    32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000), 0, none});
        rows.push_back('{build_pair(2147483647, 2147483647, 2147483647,
                                    -2147483648, -2147483648, -2147483648,
                                    32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000), 0, none});
        rows.push_back('{build_pair(2147483647, 0, 0, -2147483648, 0, 0,
                                    -32'sh4000_0000, 0, 0), 0, none});
        rows.push_back('{build_pair(0, 0, 0, 65536, 0, 0, 32'sh4000_0000, 0, 0), 0, none});
        rows.push_back('{build_pair(0, 0, 0, 0, 0, -65536, 0, 0, 32'sh4000_0000), 0, none});
        rows.push_back('{build_pair(0, 0, 0, 0, 2, 0, 0, 32'sh7FFF_FFFF, 0), 0, none});
        rows.push_back('{build_pair(0, 0, 0, 0, 2, 0, 0, 32'sh8000_0000, 0), 0, none});
        rows.push_back('{build_pair(100, -200, 300, 100, -200, 301,
                                    32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh4000_0000), 0, none});
        rows.push_back('{build_pair(0, 0, 0, 3 << 16, 4 << 16, 0,
                                    32'sh2666_6666, 32'sh3333_3333, 0), 0, none});
        rows.push_back('{build_pair(-5, -5, -5, 5, 5, 5,
                                    32'sh24F3_4E8B, 32'sh24F3_4E8B, 32'sh24F3_4E8B), 0, none});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[j])
            send_pair(rows[j].pr, rows[j].typed, rows[j].want);

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == PAUSE_AT)
            begin
                // hold off until the pipeline has drained
                in_valid <= 1'b0;
                while (pending_kernels.size() != 0)
                    @(posedge clk);
            end
            if (i == QUIET_FROM)
                quiet = 1'b1;
            rw.pr = rand_pair();
            send_pair(rw.pr, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_kernels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // receiver stall bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clk);
        end
    end

    // result check
    always @(posedge clk)
    begin
        kernel_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_kernels.size() == 0)
            begin
                $display("%0t: result with nothing expected, value %h", $realtime, kernel_value);
                fails++;
            end
            else
            begin
                w = pending_kernels.pop_front();
                if (kernel_value !== w.kv)
                begin
                    $display("%0t: kernel_value expected %h actual %h",
                             $realtime, w.kv, kernel_value);
                    fails++;
                end
                if (singular !== w.sing)
                begin
                    $display("%0t: singular expected %b actual %b", $realtime, w.sing, singular);
                    fails++;
                end
                if (saturated !== w.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $realtime, w.sat, saturated);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== laplace_double_layer_kernel.f =====
+incdir+sv
sv/ldlk_pkg.sv
sv/ldlk_front.sv
sv/ldlk_sqrt.sv
sv/ldlk_den.sv
sv/ldlk_div.sv
sv/laplace_double_layer_kernel.sv
sv/ldlk_port_check.sv
test/laplace_double_layer_kernel_test.sv
